/* sv/rbe_pkg.sv */
`timescale 1ns / 1ps

package rbe_pkg;

  // Defaults for the top-level parameters.
  localparam int SCALE_BITS_DEF = 14;
  localparam int ALPHABET_DEF   = 256;

  // Field widths, sized for the largest supported scale.
  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int FREQ_W = 15;
  localparam int CUM_W  = 14;
  localparam int S0_W   = 4;
  localparam int ACC_W  = 24;
  localparam int CNT_W  = 5;
  localparam int BYTE_W = 8;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIN  = 2'd2;

  typedef enum logic [1:0] {
    OP_ENC,
    OP_FIN,
    OP_ERR
  } op_kind_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SYM_W-1:0]  symbol;
    logic [FREQ_W-1:0] freq_in;
    logic [CUM_W-1:0]  cum_freq_in;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              error;
  } out_word_t;

  // One symbol table entry: renormalization shift base, cumulative and frequency.
  typedef struct packed {
    logic [S0_W-1:0]   s0;
    logic [CUM_W-1:0]  cum;
    logic [FREQ_W-1:0] freq;
  } tbl_entry_t;

  typedef struct packed {
    op_kind_e   kind;
    tbl_entry_t ent;
  } op_t;

endpackage

/* sv/rbe_front.sv */
`timescale 1ns / 1ps

module rbe_front import rbe_pkg::*; #(
  parameter int SCALE_BITS = SCALE_BITS_DEF,
  parameter int ALPHABET   = ALPHABET_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output op_t      q_data_o
);

  localparam int IW = $clog2(ALPHABET);
  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(1 << SCALE_BITS);
  localparam logic [CUM_W-1:0]  CUM_MASK = CUM_W'((1 << SCALE_BITS) - 1);

  function automatic logic [S0_W-1:0] width_of(input logic [FREQ_W-1:0] v);
    logic [S0_W-1:0] w;
    w = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (v[i]) begin
        w = S0_W'(i + 1);
      end
    end
    return w;
  endfunction

  tbl_entry_t tbl_mem_q [ALPHABET];
  logic [ALPHABET-1:0] vld_q;

  logic       s1_valid_q, s1_valid_d;
  logic       s1_fin_q;
  logic       s1_ok_q;
  tbl_entry_t rd_q;

  logic          accept;
  logic          in_range;
  logic [IW-1:0] idx;
  logic          is_load, is_enc, is_fin;
  tbl_entry_t    new_ent;
  logic [FREQ_W-1:0] fsat;

  assign idx      = in_i.symbol[IW-1:0];
  assign in_range = {1'b0, in_i.symbol} < (SYM_W + 1)'(ALPHABET);
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    is_load = 1'b0;
    is_enc  = 1'b0;
    is_fin  = 1'b0;
    case (in_i.cmd)
      CMD_LOAD: is_load = 1'b1;
      CMD_ENC:  is_enc  = 1'b1;
      CMD_FIN:  is_fin  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    fsat         = (in_i.freq_in > FREQ_MAX) ? FREQ_MAX : in_i.freq_in;
    new_ent.freq = fsat;
    new_ent.cum  = in_i.cum_freq_in & CUM_MASK;
    new_ent.s0   = S0_W'(SCALE_BITS + 1) - width_of(fsat);
  end

  // A held encode or finish word blocks the input until the queue has room.
  assign q_push_o   = s1_valid_q && !q_full_i;
  assign in_stall_o = s1_valid_q && q_full_i;

  always_comb begin
    s1_valid_d = s1_valid_q && !q_push_o;
    if (accept && (is_enc || is_fin)) begin
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    q_data_o.ent = rd_q;
    if (s1_fin_q) begin
      q_data_o.kind = OP_FIN;
    end else if (s1_ok_q && (rd_q.freq != '0)) begin
      q_data_o.kind = OP_ENC;
    end else begin
      q_data_o.kind = OP_ERR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept && is_load && in_range) begin
        vld_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_load && in_range) begin
      tbl_mem_q[idx] <= new_ent;
    end
    if (accept && (is_enc || is_fin)) begin
      rd_q     <= tbl_mem_q[idx];
      s1_fin_q <= is_fin;
      s1_ok_q  <= in_range && vld_q[idx];
    end
  end

endmodule

/* sv/rbe_queue.sv */
`timescale 1ns / 1ps

module rbe_queue import rbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output op_t  data_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  op_t            slot_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == FULL_CNT;
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/rbe_back.sv */
`timescale 1ns / 1ps

module rbe_back import rbe_pkg::*; #(
  parameter int SCALE_BITS = SCALE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_o
);

  localparam int SW = SCALE_BITS + 4;
  localparam int VW = SCALE_BITS + 3;
  localparam logic [SW-1:0] TOP_STATE = SW'(1) << (SCALE_BITS + 3);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_ERR  = 3'd6;

  logic [2:0]        st_q, st_d;
  logic [SW-1:0]     x_q, x_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FREQ_W-1:0] f_q, f_d;
  logic [CUM_W-1:0]  cum_q, cum_d;
  logic [S0_W-1:0]   s0_q, s0_d;
  logic [VW-1:0]     v_q, v_d;
  logic [2:0]        q_q, q_d;
  logic [1:0]        k_q, k_d;
  logic [1:0]        n_q, n_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic              slot_free;
  logic [SW-1:0]     thr;
  logic              borrow;
  logic [S0_W-1:0]   sh;
  logic [SW-1:0]     low_bits;
  logic [SW-1:0]     v_start;
  logic [VW-1:0]     dsub;
  logic [SW-1:0]     sum;
  logic [31:0]       z;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    // The shift drops by one when the state lies below freq scaled to the top range.
    thr      = SW'(f_q) << ({1'b0, s0_q} + 5'd3);
    borrow   = x_q < thr;
    sh       = (borrow && (s0_q != '0)) ? s0_q - 1'b1 : s0_q;
    low_bits = x_q & ~({SW{1'b1}} << sh);
    v_start  = (x_q >> sh) - (SW'(f_q) << 3);
    dsub     = VW'(f_q) << k_q;
    sum      = (SW'(q_q) << SCALE_BITS) + SW'(v_q) + SW'(cum_q);
    z        = (32'(x_q) << cnt_q) | 32'(acc_q);
  end

  always_comb begin
    st_d        = st_q;
    x_d         = x_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    f_d         = f_q;
    cum_d       = cum_q;
    s0_d        = s0_q;
    v_d         = v_q;
    q_d         = q_q;
    k_d         = k_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    op_pop_o    = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          f_d      = op_i.ent.freq;
          cum_d    = op_i.ent.cum;
          s0_d     = op_i.ent.s0;
          n_d      = '0;
          case (op_i.kind)
            OP_ENC:  st_d = ST_PREP;
            OP_FIN:  st_d = ST_FIN;
            default: st_d = ST_ERR;
          endcase
        end
      end
      ST_PREP: begin
        acc_d = acc_q | (ACC_W'(low_bits) << cnt_q);
        cnt_d = cnt_q + CNT_W'(sh);
        v_d   = VW'(v_start);
        q_d   = '0;
        k_d   = 2'd2;
        st_d  = ST_DIV;
      end
      ST_DIV: begin
        // One restoring step per cycle, quotient MSB first.
        if (v_q >= dsub) begin
          v_d      = v_q - dsub;
          q_d[k_q] = 1'b1;
        end
        if (k_q == 2'd0) begin
          st_d = ST_UPD;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      ST_UPD: begin
        x_d  = TOP_STATE | (sum & (TOP_STATE - 1'b1));
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cnt_q >= CNT_W'(BYTE_W)) begin
          if (slot_free) begin
            out_valid_d    = 1'b1;
            out_d.out_byte = acc_q[BYTE_W-1:0];
            out_d.last     = 1'b0;
            out_d.error    = 1'b0;
            acc_d          = acc_q >> BYTE_W;
            cnt_d          = cnt_q - CNT_W'(BYTE_W);
          end
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_d    = 1'b1;
          out_d.out_byte = z[{n_q, 3'b000} +: BYTE_W];
          out_d.last     = n_q == 2'd3;
          out_d.error    = 1'b0;
          n_d            = n_q + 1'b1;
          if (n_q == 2'd3) begin
            x_d   = TOP_STATE;
            acc_d = '0;
            cnt_d = '0;
            st_d  = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_d    = 1'b1;
          out_d.out_byte = '0;
          out_d.last     = 1'b0;
          out_d.error    = 1'b1;
          st_d           = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      x_q         <= TOP_STATE;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      x_q         <= x_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    cum_q <= cum_d;
    s0_q  <= s0_d;
    v_q   <= v_d;
    q_q   <= q_d;
    k_q   <= k_d;
    n_q   <= n_d;
    out_q <= out_d;
  end

endmodule

/* sv/rans_byte_encoder.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Word
// in       input      in_valid_i / in_stall_o  in_i  (cmd, symbol, freq_in, cum_freq_in)
// out      output     out_valid_o / out_stall_i out_o (out_byte, last, error)
//
// A load word is written into the front-end table and never reaches the back end.
// An encode word passes the back end through prepare, divide, update and emit states,
// the divide being three restoring steps; emit sends 0 to 2 bytes.
// A finish word emits four bytes, an error result one; a two-entry queue sits between.
// Reset clears the table valid bits at once, so no clearing pass follows reset.
// The input stalls only while the queue is full; output stalls hold the back end.

module rans_byte_encoder import rbe_pkg::*; #(
  parameter int SCALE_BITS = SCALE_BITS_DEF,
  parameter int ALPHABET   = ALPHABET_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_o
);

  logic q_full, q_push, q_valid, q_pop;
  op_t  q_in, q_out;

  rbe_front #(
    .SCALE_BITS (SCALE_BITS),
    .ALPHABET   (ALPHABET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  rbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  rbe_back #(
    .SCALE_BITS (SCALE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_out),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // The back end only takes work that the queue actually holds.
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  // The input may only be held back by a full queue.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled while the queue had room");

  // A word pushed into a full queue would be lost.
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into a full queue");

  // The closing byte of a stream never carries the error flag.
  a_last_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last) |-> !out_o.error)
    else $error("last byte flagged as error");

endmodule

/* test/rans_byte_encoder_tb.sv */
`timescale 1ns / 1ps

module rans_byte_encoder_tb;
  import rbe_pkg::*;

  localparam int SB         = SCALE_BITS_DEF;
  localparam int PREC       = 3;
  localparam int CODER_BITS = SB + PREC;
  localparam logic [31:0] TOP_X = 32'd1 << CODER_BITS;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_o;

  rans_byte_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // Predicted coder: symbol table, state and pending bits.
  logic [FREQ_W-1:0]   sym_freq  [ALPHABET_DEF];
  logic [CUM_W-1:0]    sym_cum   [ALPHABET_DEF];
  logic [31:0]         sym_delta [ALPHABET_DEF];
  logic [CODER_BITS:0] coder_x;
  logic [ACC_W-1:0]    coder_acc;
  logic [CNT_W-1:0]    coder_cnt;

  out_word_t expected_bytes[$];
  out_word_t want;

  int n_loads, n_encodes, n_zero_freq, n_finishes, n_spare;
  int n_checked, n_bad;
  int stall_left, stall_roll;
  bit tx_steady, rx_steady;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int width_bits(logic [31:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic void expect_word(logic [7:0] b, logic l, logic e);
    out_word_t r;
    r.out_byte = b;
    r.last     = l;
    r.error    = e;
    expected_bytes.push_back(r);
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Works out the output words caused by one accepted input word.
  function automatic void encode_step(in_word_t w);
    logic [31:0] f, x, sh, v, q, d, acc, mix;
    int cnt;
    case (w.cmd)
      CMD_LOAD: begin
        f  = (w.freq_in > (32'd1 << SB)) ? (32'd1 << SB) : 32'(w.freq_in);
        sh = 32'(SB + 1 - width_bits(f));
        sym_freq[w.symbol]  = f[FREQ_W-1:0];
        sym_cum[w.symbol]   = w.cum_freq_in;
        sym_delta[w.symbol] = (sh << (CODER_BITS + 1)) - (f << (sh + PREC));
        n_loads++;
      end
      CMD_ENC: begin
        n_encodes++;
        f = 32'(sym_freq[w.symbol]);
        if (f == 0) begin
          n_zero_freq++;
          expect_word(8'h00, 1'b0, 1'b1);
        end else begin
          x  = 32'(coder_x);
          sh = (x + sym_delta[w.symbol]) >> (CODER_BITS + 1);
          if (sh > SB) sh = SB;
          acc = 32'(coder_acc) | ((x & ((32'd1 << sh) - 32'd1)) << coder_cnt);
          cnt = int'(coder_cnt) + int'(sh);
          while (cnt >= 8) begin
            expect_word(acc[7:0], 1'b0, 1'b0);
            acc = acc >> 8;
            cnt -= 8;
          end
          coder_acc = acc[ACC_W-1:0];
          coder_cnt = CNT_W'(cnt);
          // Three restoring steps give a quotient of 0 to 7.
          v = (x >> sh) - (f << PREC);
          q = 0;
          for (int k = PREC; k > 0; k--) begin
            d = f << (k - 1);
            if (v >= d) begin
              v = v - d;
              q = q | (32'd1 << (k - 1));
            end
          end
          mix = (q << SB) + v + 32'(sym_cum[w.symbol]);
          mix = (mix & (TOP_X - 32'd1)) | TOP_X;
          coder_x = mix[CODER_BITS:0];
        end
      end
      CMD_FIN: begin
        n_finishes++;
        mix = (32'(coder_x) << coder_cnt) | 32'(coder_acc);
        for (int k = 0; k < 4; k++) begin
          expect_word(mix[8*k +: 8], k == 3, 1'b0);
        end
        coder_x   = TOP_X[CODER_BITS:0];
        coder_acc = '0;
        coder_cnt = '0;
      end
      default: n_spare++;
    endcase
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [FREQ_W-1:0] f, input logic [CUM_W-1:0] c);
    in_word_t w;
    int gap;
    w.cmd         = cmd;
    w.symbol      = sym;
    w.freq_in     = f;
    w.cum_freq_in = c;
    gap = tx_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_i       <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    encode_step(w);
  endtask

  task automatic wait_for_drain();
    int guard;
    guard = 0;
    while (expected_bytes.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Table entries at the field extremes, including a saturated frequency.
  task automatic test_table_extremes();
    send_word(CMD_LOAD, 8'd0,   15'd1,     14'd0);
    send_word(CMD_LOAD, 8'd255, 15'd16384, 14'd0);
    send_word(CMD_LOAD, 8'd128, 15'd32767, 14'd16383);
    send_word(CMD_LOAD, 8'd85,  15'd5461,  14'd100);
    send_word(CMD_LOAD, 8'd170, 15'd10922, 14'd5461);
    send_word(CMD_LOAD, 8'd7,   15'd0,     14'd16383);
  endtask

  // Smallest and largest frequencies, an overflowing entry, zero-frequency
  // symbols and the unused command.
  task automatic test_encode_corners();
    send_word(CMD_ENC,   8'd0,   15'd32767, 14'd16383);
    send_word(CMD_ENC,   8'd255, 15'd0,     14'd0);
    send_word(CMD_ENC,   8'd128, 15'd0,     14'd0);
    send_word(CMD_ENC,   8'd85,  15'd0,     14'd0);
    send_word(CMD_ENC,   8'd170, 15'd0,     14'd0);
    send_word(CMD_ENC,   8'd7,   15'd0,     14'd0);
    send_word(CMD_ENC,   8'd42,  15'd0,     14'd0);
    send_word(CMD_SPARE, 8'd255, 15'd32767, 14'd16383);
    send_word(CMD_ENC,   8'd0,   15'd0,     14'd0);
    send_word(CMD_ENC,   8'd0,   15'd0,     14'd0);
    send_word(CMD_ENC,   8'd0,   15'd0,     14'd0);
  endtask

  // A finish flushes the coder; a second one works on the reset state.
  task automatic test_finish_restart();
    send_word(CMD_FIN, 8'd0,   15'd0, 14'd0);
    send_word(CMD_FIN, 8'd255, 15'd0, 14'd0);
    send_word(CMD_ENC, 8'd170, 15'd0, 14'd0);
    send_word(CMD_FIN, 8'd0,   15'd0, 14'd0);
  endtask

  // Streams: a fresh consistent table, symbols drawn from it, then a finish.
  // Some noise: stray loads, symbols outside the table and the unused command.
  task automatic test_random_streams(input int budget);
    logic [SYM_W-1:0] syms[$];
    bit [255:0] taken;
    int n_syms, remaining, f, cum, len, r, pick, sent;
    sent = 0;
    while (sent < budget) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      syms.delete();
      taken = '0;
      n_syms = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
      remaining = 1 << SB;
      cum = 0;
      for (int i = 0; i < n_syms; i++) begin
        pick = $urandom_range(0, 255);
        while (taken[pick]) pick = $urandom_range(0, 255);
        taken[pick] = 1'b1;
        syms.push_back(pick[SYM_W-1:0]);
        if (i == n_syms - 1) f = remaining;
        else if ($urandom_range(0, 1) == 1) f = $urandom_range(1, remaining - (n_syms - 1 - i));
        else f = 1 + $urandom_range(0, (remaining - (n_syms - i)) / 8);
        send_word(CMD_LOAD, pick[SYM_W-1:0], f[FREQ_W-1:0], cum[CUM_W-1:0]);
        remaining -= f;
        cum += f;
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_word(CMD_LOAD, SYM_W'($urandom_range(0, 255)), FREQ_W'($urandom_range(0, 32767)),
                  CUM_W'($urandom_range(0, 16383)));
        sent++;
      end
      len = $urandom_range(2, 12);
      for (int j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          send_word(CMD_ENC, syms[$urandom_range(0, syms.size() - 1)],
                    FREQ_W'($urandom_range(0, 32767)), CUM_W'($urandom_range(0, 16383)));
          sent++;
        end else if (r < 95) begin
          send_word(CMD_ENC, SYM_W'($urandom_range(0, 255)), FREQ_W'($urandom_range(0, 32767)),
                    CUM_W'($urandom_range(0, 16383)));
          sent++;
        end else begin
          send_word(CMD_SPARE, SYM_W'($urandom_range(0, 255)),
                    FREQ_W'($urandom_range(0, 32767)), CUM_W'($urandom_range(0, 16383)));
        end
      end
      // Now and then a stream runs on into the next table without a finish.
      if ($urandom_range(0, 5) != 0) begin
        send_word(CMD_FIN, SYM_W'($urandom_range(0, 255)), FREQ_W'($urandom_range(0, 32767)),
                  CUM_W'($urandom_range(0, 16383)));
        sent++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // The sender holds off until the output side has delivered every word,
  // then flushes whatever state the coder carried across the pause.
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_for_drain();
    repeat (5) @(posedge clk_i);
    send_word(CMD_FIN, 8'd0, 15'd0, 14'd0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_bytes.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected output word: byte %02h last %0b error %0b",
                   out_o.out_byte, out_o.last, out_o.error);
        n_bad++;
      end else begin
        want = expected_bytes.pop_front();
        n_checked++;
        if (out_o.out_byte !== want.out_byte || out_o.last !== want.last ||
            out_o.error !== want.error) begin
          if (n_bad < 10)
            $display("output word %0d: expected byte %02h last %0b error %0b,",
                     n_checked, want.out_byte, want.last, want.error,
                     " got byte %02h last %0b error %0b",
                     out_o.out_byte, out_o.last, out_o.error);
          n_bad++;
        end
      end
    end
    if (!rst_ni || rx_steady) begin
      stall_left = 0;
    end else if (stall_left == 0) begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 72) stall_left = 0;
      else if (stall_roll < 95) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(8, 30);
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d output words still expected", expected_bytes.size());
    $display("rans_byte_encoder test failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < ALPHABET_DEF; i++) begin
      sym_freq[i]  = '0;
      sym_cum[i]   = '0;
      sym_delta[i] = '0;
    end
    coder_x   = TOP_X[CODER_BITS:0];
    coder_acc = '0;
    coder_cnt = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_extremes();
    test_encode_corners();
    test_finish_restart();
    test_random_streams(40);
    test_drain_pause();
    test_random_streams(40);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_for_drain();
    repeat (40) @(posedge clk_i);
    if (expected_bytes.size() != 0) begin
      $display("%0d expected output words never arrived", expected_bytes.size());
      n_bad += expected_bytes.size();
    end

    $display("Covered %0d loads, %0d encodes (%0d on zero frequency),",
             n_loads, n_encodes, n_zero_freq,
             " %0d finishes, %0d spare commands.", n_finishes, n_spare);
    $display("Checked %0d output words, %0d of them wrong or unexpected.", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("rans_byte_encoder test passed");
    end else begin
      $display("rans_byte_encoder test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rbe_pkg.sv
sv/rbe_front.sv
sv/rbe_queue.sv
sv/rbe_back.sv
sv/rans_byte_encoder.sv
test/rans_byte_encoder_tb.sv
